>>> hdl/twzs_pkg.sv
// Shared types and constants for the trigger window zero suppression block.
// Holds the beat structs, the operation codes, the register map and the memory geometry.
// Depends on nothing else.
package twzs_pkg;

	// Delay memory geometry and ADC word width.
	localparam int DELAY_DEPTH  = 8192;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ADDR_W       = $clog2(DELAY_DEPTH);

	// Field widths fixed by the interface.
	localparam int VALUE_W = 16;
	localparam int POS_W   = 32;
	localparam int PRE_W   = 13;
	localparam int POST_W  = 17;
	localparam int ENTRY_W = VALUE_W + 1;

	// Configuration register map (word index, byte address / 4).
	localparam logic [1:0] REG_THRESHOLD     = 2'd0;
	localparam logic [1:0] REG_PRE_COUNT     = 2'd1;
	localparam logic [1:0] REG_POST_COUNT    = 2'd2;
	localparam logic [1:0] REG_RECORD_LENGTH = 2'd3;

	// Register reset values.
	localparam logic signed [VALUE_W-1:0] THRESHOLD_RST     = 16'sd0;
	localparam logic [PRE_W-1:0]          PRE_COUNT_RST     = 13'd7407;
	localparam logic [POST_W-1:0]         POST_COUNT_RST    = 17'd74073;
	localparam logic [POS_W-1:0]          RECORD_LENGTH_RST = 32'hFFFF_FFFF;

	// Input operation codes.
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_DRAIN  = 1'b1
	} op_t;

	// One incoming ADC beat.
	typedef struct packed {
		op_t                        operation;
		logic signed [VALUE_W-1:0]  sample;
	} adc_beat_t;

	// One kept sample leaving the block.
	typedef struct packed {
		logic signed [VALUE_W-1:0]  kept_sample;
		logic [POS_W-1:0]           sample_position;
	} kept_beat_t;

endpackage

>>> hdl/trigger_window_zero_suppression.sv
// Top level of the trigger window zero suppression block: trigger logic, delay memory, output.
// Depends on twzs_pkg for beat types, operation codes and the register map.
// Single module; the delay memory is an array inside it.

// The block accepts one ADC beat per clock and is never slowed by its own work: adc_stall
// rises only while a kept sample waits in the output register and the next kept sample
// read from the delay memory has nowhere to go. Each sample beat writes one entry of the
// delay memory (sample plus keep mark) and, once more than min(pre_count, DELAY_DEPTH-1)
// samples are held, reads the oldest one back; a drain beat only reads. A kept sample
// reaches the kept channel through the memory read register, then the output register.
// The single write port and single read port of the delay memory set
// this rate of one beat per cycle. The delay memory is not cleared at reset; every entry
// is written before it is read, so no clearing pass is needed and the block is ready at
// once. Configuration registers reset to threshold 0, pre_count 7407, post_count 74073
// and record_length 0xFFFFFFFF, and must be written only while the block is idle.
module trigger_window_zero_suppression (
	input  logic                   clk,
	input  logic                   arst_n,
	// ADC channel
	input  logic                   adc_valid,
	output logic                   adc_stall,
	input  twzs_pkg::adc_beat_t    adc_beat,
	// Kept sample channel
	output logic                   kept_valid,
	input  logic                   kept_stall,
	output twzs_pkg::kept_beat_t   kept_beat,
	// Configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import twzs_pkg::*;

	// Configuration registers.
	logic signed [VALUE_W-1:0] threshold_q;
	logic [PRE_W-1:0]          pre_count_q;
	logic [POST_W-1:0]         post_count_q;
	logic [POS_W-1:0]          record_length_q;

	// Control state.
	logic [POS_W-1:0]  write_pos_q;
	logic [POS_W-1:0]  output_pos_q;
	logic [ADDR_W-1:0] waddr_q;
	logic [ADDR_W-1:0] raddr_q;
	logic [POST_W-1:0] post_left_q;
	logic [PRE_W-1:0]  pre_cover_q;
	logic              extending_q;
	logic              scan_stopped_q;

	// Delay memory and its read stage.
	logic [ENTRY_W-1:0] delay_mem [DELAY_DEPTH];
	logic [ENTRY_W-1:0] rdata_s1;
	logic               valid_s1;
	logic [POS_W-1:0]   pos_s1;
	logic               pre_keep_s1;
	logic               bypass_s1;
	logic [ENTRY_W-1:0] bypass_data_s1;

	// Output register.
	logic       out_valid_q;
	kept_beat_t out_beat_q;

	// Combinational decisions for the beat on the input.
	logic                      accept;
	logic                      is_sample;
	logic signed [VALUE_W-1:0] sample_ext;
	logic                      below;
	logic                      in_record;
	logic                      no_room;
	logic                      mark;
	logic                      trig;
	logic [POST_W-1:0]         post_left_d;
	logic                      extending_d;
	logic                      scan_stopped_d;
	logic [PRE_W-1:0]          pre_eff;
	logic [POS_W-1:0]          write_pos_inc;
	logic [POS_W-1:0]          trig_dist;
	logic [PRE_W-1:0]          pre_cover_new;
	logic [PRE_W-1:0]          pre_cover_d;
	logic                      pre_keep;
	logic                      do_read;
	logic                      do_write;
	logic [ENTRY_W-1:0]        wdata;
	logic [ENTRY_W-1:0]        entry_s1;
	logic                      keep_s1;
	logic                      out_free;
	logic                      hold_s1;

	assign pready = 1'b1;

	// Register writes on the access cycle of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q     <= THRESHOLD_RST;
			pre_count_q     <= PRE_COUNT_RST;
			post_count_q    <= POST_COUNT_RST;
			record_length_q <= RECORD_LENGTH_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_THRESHOLD:     threshold_q     <= pwdata[VALUE_W-1:0];
				REG_PRE_COUNT:     pre_count_q     <= pwdata[PRE_W-1:0];
				REG_POST_COUNT:    post_count_q    <= pwdata[POST_W-1:0];
				REG_RECORD_LENGTH: record_length_q <= pwdata[POS_W-1:0];
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (paddr[3:2])
			REG_THRESHOLD:     prdata = 32'(threshold_q);
			REG_PRE_COUNT:     prdata = 32'(pre_count_q);
			REG_POST_COUNT:    prdata = 32'(post_count_q);
			REG_RECORD_LENGTH: prdata = record_length_q;
		endcase
	end

	// Handshake: the pipeline holds only when a kept sample cannot move to the output.
	assign entry_s1  = bypass_s1 ? bypass_data_s1 : rdata_s1;
	assign keep_s1   = entry_s1[ENTRY_W-1] || pre_keep_s1;
	assign out_free  = !out_valid_q || !kept_stall;
	assign hold_s1   = valid_s1 && keep_s1 && !out_free;
	assign adc_stall = hold_s1;
	assign accept    = adc_valid && !adc_stall;

	// Sample decode and the basic comparisons.
	assign is_sample  = (adc_beat.operation == OP_SAMPLE);
	assign sample_ext = VALUE_W'($signed(adc_beat.sample[SAMPLE_WIDTH-1:0]));
	assign below      = sample_ext < threshold_q;
	assign in_record  = write_pos_q < record_length_q;
	assign no_room    = ({1'b0, write_pos_q} + 33'(post_count_q) + 33'd1)
		> {1'b0, record_length_q};
	assign pre_eff    = (32'(pre_count_q) < 32'(DELAY_DEPTH - 1))
		? pre_count_q : PRE_W'(DELAY_DEPTH - 1);

	// Trigger, post-trigger and extension marking for a sample beat.
	always_comb begin
		mark           = 1'b0;
		trig           = 1'b0;
		post_left_d    = post_left_q;
		extending_d    = extending_q;
		scan_stopped_d = scan_stopped_q;
		if (post_left_q != '0 && in_record) begin
			mark        = 1'b1;
			post_left_d = post_left_q - 1'b1;
			if (post_left_q == POST_W'(1)) begin
				extending_d = 1'b1;
			end
		end else begin
			post_left_d = '0;
			if (extending_q) begin
				if (in_record && below) begin
					mark = 1'b1;
				end else begin
					extending_d = 1'b0;
				end
			end
			if (!mark && !scan_stopped_q) begin
				if (no_room) begin
					scan_stopped_d = 1'b1;
				end else if (below) begin
					mark        = 1'b1;
					trig        = 1'b1;
					post_left_d = post_count_q;
					extending_d = (post_count_q == '0);
				end
			end
		end
	end

	// Read decision and pre-trigger coverage; a trigger sets coverage before this read.
	assign write_pos_inc = write_pos_q + 32'd1;
	assign trig_dist     = write_pos_q - output_pos_q;
	assign do_write      = accept && is_sample;
	assign do_read       = accept && (is_sample
		? ((write_pos_inc - output_pos_q) > 32'(pre_eff))
		: (write_pos_q != output_pos_q));
	assign wdata         = {mark, sample_ext};

	always_comb begin
		pre_cover_new = pre_cover_q;
		if (is_sample && trig) begin
			pre_cover_new = (trig_dist < 32'(pre_eff)) ? trig_dist[PRE_W-1:0] : pre_eff;
		end
		pre_keep    = (pre_cover_new != '0);
		pre_cover_d = (do_read && pre_keep) ? pre_cover_new - 1'b1 : pre_cover_new;
	end

	// Control state update on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q    <= '0;
			output_pos_q   <= '0;
			waddr_q        <= '0;
			raddr_q        <= '0;
			post_left_q    <= '0;
			pre_cover_q    <= '0;
			extending_q    <= 1'b0;
			scan_stopped_q <= 1'b0;
		end else if (accept) begin
			pre_cover_q <= pre_cover_d;
			if (is_sample) begin
				write_pos_q    <= write_pos_inc;
				waddr_q        <= (waddr_q == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : waddr_q + 1'b1;
				post_left_q    <= post_left_d;
				extending_q    <= extending_d;
				scan_stopped_q <= scan_stopped_d;
			end
			if (do_read) begin
				output_pos_q <= output_pos_q + 32'd1;
				raddr_q      <= (raddr_q == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : raddr_q + 1'b1;
			end
		end
	end

	// Delay memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (do_write) begin
			delay_mem[waddr_q] <= wdata;
		end
		if (do_read) begin
			rdata_s1 <= delay_mem[raddr_q];
		end
	end

	// Read stage control; a read of the entry written in the same cycle takes the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold_s1) begin
			valid_s1 <= do_read;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			pos_s1         <= output_pos_q;
			pre_keep_s1    <= pre_keep;
			bypass_s1      <= do_write && (waddr_q == raddr_q);
			bypass_data_s1 <= wdata;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && keep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && keep_s1) begin
			out_beat_q.kept_sample     <= entry_s1[VALUE_W-1:0];
			out_beat_q.sample_position <= pos_s1;
		end
	end

	assign kept_valid = out_valid_q;
	assign kept_beat  = out_beat_q;

endmodule

>>> bench/trigger_window_zero_suppression_test.sv
// Self-checking bench for trigger_window_zero_suppression: APB register setup, ADC beats in,
// kept samples out, with a scoreboard class that predicts every kept beat.
// Depends on twzs_pkg and the trigger_window_zero_suppression top level.
`timescale 1ns / 1ps

module trigger_window_zero_suppression_test;
	import twzs_pkg::*;

	localparam int          QUIET_CYCLES = 8;
	localparam int          END_WAIT     = 5000;
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned REC_MAX      = 32'hFFFF_FFFF;
	localparam int          DRAIN_STEP   = 65536;
	localparam adc_beat_t   DRAIN_BEAT   = '{operation: OP_DRAIN, sample: 16'sd0};

	// Tracks the suppression state and holds the kept beats still due from the block.
	class suppression_tracker;
		logic signed [VALUE_W-1:0] thr;
		int unsigned               pre_cnt;
		int unsigned               post_cnt;
		int unsigned               rec_len;
		logic [ENTRY_W-1:0]        held [DELAY_DEPTH];
		int unsigned               wr_pos;
		int unsigned               rd_pos;
		int unsigned               post_remaining;
		int unsigned               pre_pass;
		bit                        in_extension;
		bit                        scan_done;
		kept_beat_t                pending_kept [$];
		int                        errors;

		function new();
			thr            = THRESHOLD_RST;
			pre_cnt        = PRE_COUNT_RST;
			post_cnt       = POST_COUNT_RST;
			rec_len        = RECORD_LENGTH_RST;
			wr_pos         = 0;
			rd_pos         = 0;
			post_remaining = 0;
			pre_pass       = 0;
			in_extension   = 1'b0;
			scan_done      = 1'b0;
			errors         = 0;
		endfunction

		function void set_register(input logic [1:0] idx, input logic [31:0] value);
			case (idx)
				REG_THRESHOLD:     thr      = value[VALUE_W-1:0];
				REG_PRE_COUNT:     pre_cnt  = value[PRE_W-1:0];
				REG_POST_COUNT:    post_cnt = value[POST_W-1:0];
				REG_RECORD_LENGTH: rec_len  = value;
				default: ;
			endcase
		endfunction

		// Oldest held sample leaves; it is kept if marked or still inside a pre-trigger span.
		function void read_oldest();
			logic [ENTRY_W-1:0] e;
			kept_beat_t         k;
			bit                 keep;
			e    = held[rd_pos % DELAY_DEPTH];
			keep = e[VALUE_W] || (pre_pass > 0);
			if (pre_pass > 0)
				pre_pass--;
			if (keep) begin
				k.kept_sample     = e[VALUE_W-1:0];
				k.sample_position = rd_pos;
				pending_kept      = {pending_kept, k};
			end
			rd_pos++;
		endfunction

		function void take_adc_beat(input adc_beat_t b);
			int unsigned               pre_eff;
			int unsigned               p;
			int unsigned               d;
			logic signed [VALUE_W-1:0] s;
			bit                        in_rec;
			bit                        mark;
			bit                        trig;
			pre_eff = (pre_cnt < DELAY_DEPTH - 1) ? pre_cnt : DELAY_DEPTH - 1;
			if (b.operation == OP_DRAIN) begin
				if (wr_pos != rd_pos)
					read_oldest();
				return;
			end
			p      = wr_pos;
			s      = b.sample;
			in_rec = p < rec_len;
			mark   = 1'b0;
			trig   = 1'b0;
			// Post window first, then extension, then a fresh trigger if room remains.
			if (post_remaining != 0 && in_rec) begin
				mark = 1'b1;
				post_remaining--;
				if (post_remaining == 0)
					in_extension = 1'b1;
			end else begin
				post_remaining = 0;
				if (in_extension) begin
					if (in_rec && s < thr)
						mark = 1'b1;
					else
						in_extension = 1'b0;
				end
				if (!mark && !scan_done) begin
					if (64'(p) + 64'(post_cnt) + 64'd1 > 64'(rec_len)) begin
						scan_done = 1'b1;
					end else if (s < thr) begin
						mark           = 1'b1;
						trig           = 1'b1;
						post_remaining = post_cnt;
						in_extension   = (post_cnt == 0);
					end
				end
			end
			held[p % DELAY_DEPTH] = {mark, s};
			if (trig) begin
				d        = p - rd_pos;
				pre_pass = (d < pre_eff) ? d : pre_eff;
			end
			wr_pos = p + 1;
			if (wr_pos - rd_pos > pre_eff)
				read_oldest();
		endfunction

		function void check_kept(input kept_beat_t got);
			kept_beat_t want;
			if (pending_kept.size() == 0) begin
				$error("kept beat with none expected: kept_sample %0d, sample_position %0d",
					got.kept_sample, got.sample_position);
				errors++;
				return;
			end
			want = pending_kept.pop_front();
			if (got.kept_sample !== want.kept_sample) begin
				$error("kept_sample: expected %0d, actual %0d", want.kept_sample, got.kept_sample);
				errors++;
			end
			if (got.sample_position !== want.sample_position) begin
				$error("sample_position: expected %0d, actual %0d",
					want.sample_position, got.sample_position);
				errors++;
			end
		endfunction

		function void close_out();
			if (pending_kept.size() != 0) begin
				$error("kept_sample: %0d expected beats never arrived", pending_kept.size());
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        adc_valid;
	logic        adc_stall;
	adc_beat_t   adc_beat;
	logic        kept_valid;
	logic        kept_stall;
	kept_beat_t  kept_beat;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	suppression_tracker tracker = new();
	int                 low_run = 0;
	int unsigned        cycle_count = 0;

	trigger_window_zero_suppression u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.adc_valid  (adc_valid),
		.adc_stall  (adc_stall),
		.adc_beat   (adc_beat),
		.kept_valid (kept_valid),
		.kept_stall (kept_stall),
		.kept_beat  (kept_beat),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Every accepted kept beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && kept_valid && !kept_stall)
			tracker.check_kept(kept_beat);
	end

	// Receiver back-pressure: quiet stretches, long stalls and random flicker.
	initial begin
		int r;
		int hold;
		kept_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			@(negedge clk);
			if (r < 20) begin
				kept_stall <= 1'b0;
				hold = $urandom_range(20, 150);
			end else if (r < 25) begin
				kept_stall <= 1'b1;
				hold = $urandom_range(10, 40);
			end else begin
				kept_stall <= ($urandom_range(0, 2) == 0);
				hold = 1;
			end
			if (hold > 1)
				repeat (hold - 1) @(negedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// A value strictly below the threshold, or at/above it, often close to the threshold.
	function automatic logic signed [15:0] pick_value(input bit low, input int t);
		int span;
		if (low && t > -32768) begin
			span = t + 32767;
			if ($urandom_range(0, 1))
				return 16'(t - 1 - int'($urandom_range(0, (span < 63) ? span : 63)));
			return 16'(int'($urandom_range(0, span)) - 32768);
		end
		if (!low && t < 32767) begin
			span = 32767 - t;
			if ($urandom_range(0, 1))
				return 16'(t + int'($urandom_range(0, (span < 63) ? span : 63)));
			return 16'(t + int'($urandom_range(0, span)));
		end
		return 16'(t);
	endfunction

	// Mostly quiet samples with trigger bursts, boundary values, raw noise and drains.
	function automatic adc_beat_t next_adc_beat(input int drain_pct);
		adc_beat_t b;
		int        t;
		int        r;
		t           = tracker.thr;
		b.operation = OP_SAMPLE;
		b.sample    = pick_value(1'b0, t);
		r           = $urandom_range(0, 99);
		if (r < drain_pct) begin
			b.operation = OP_DRAIN;
			b.sample    = 16'($urandom);
		end else if (low_run > 0) begin
			low_run--;
			b.sample = pick_value(1'b1, t);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				low_run  = $urandom_range(0, 12);
				b.sample = pick_value(1'b1, t);
			end else if (r < 12) begin
				b.sample = 16'(t);
			end else if (r < 22) begin
				b.sample = 16'($urandom);
			end
		end
		return b;
	endfunction

	// One ADC beat: hold it until accepted, then idle for the requested gap.
	task automatic send_adc_beat(input adc_beat_t b, input int gap);
		@(negedge clk);
		adc_valid <= 1'b1;
		adc_beat  <= b;
		@(posedge clk);
		while (adc_stall)
			@(posedge clk);
		tracker.take_adc_beat(b);
		if (gap > 0) begin
			@(negedge clk);
			adc_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every due kept beat is out and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		adc_valid <= 1'b0;
		while (tracker.pending_kept.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.set_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_settings(input int thr, input int unsigned pre, input int unsigned post,
			input int unsigned rec);
		settle();
		write_register(REG_THRESHOLD, 32'(thr));
		write_register(REG_PRE_COUNT, pre);
		write_register(REG_POST_COUNT, post);
		write_register(REG_RECORD_LENGTH, rec);
	endtask

	// One setting of the registers followed by a random beat stream.
	task automatic run_phase(input int thr, input int unsigned pre, input int unsigned post,
			input int unsigned rec, input int count, input int drain_pct, input int lead_low,
			input bit pause_mid);
		int gap;
		load_settings(thr, pre, post, rec);
		low_run = lead_low;
		for (int i = 0; i < count; i++) begin
			gap = ((i % 100) < 30) ? 0 : pick_gap();
			send_adc_beat(next_adc_beat(drain_pct), gap);
			if (pause_mid && i == count / 2)
				settle();
		end
	endtask

	// Drain steps until the delay memory holds nothing.
	task automatic drain_flush();
		while (tracker.wr_pos != tracker.rd_pos)
			send_adc_beat(DRAIN_BEAT, pick_gap());
	endtask

	initial begin
		int opening [24];
		int waited;
		adc_beat_t b;
		arst_n    = 1'b0;
		adc_valid = 1'b0;
		adc_beat  = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		opening   = '{100, 32767, -32768, 7, -5, 9, -3, -2, 0, 1, -7, 4, 4, -9, 2, 3, 6, 8,
			DRAIN_STEP, DRAIN_STEP, DRAIN_STEP, DRAIN_STEP, DRAIN_STEP, DRAIN_STEP};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A drain beat with nothing held, under the reset settings.
		send_adc_beat(DRAIN_BEAT, 0);

		// Directed: extremes, trigger near the record start, post window, extension,
		// a boundary value, overlapping pre-trigger spans, and drains past empty.
		load_settings(0, 3, 2, REC_MAX);
		foreach (opening[i]) begin
			if (opening[i] == DRAIN_STEP) begin
				b = DRAIN_BEAT;
			end else begin
				b.operation = OP_SAMPLE;
				b.sample    = 16'(opening[i]);
			end
			send_adc_beat(b, pick_gap());
		end

		// Random phases; the record end and scan stop come last since they are permanent.
		run_phase(int'($urandom_range(0, 2000)) - 1000, 0, 0, REC_MAX, 200, 5, 0, 1'b0);
		run_phase(-32768, 5, 131071, REC_MAX, 120, 5, 0, 1'b0);
		run_phase(32767, 2, 1, REC_MAX, 150, 5, 0, 1'b0);
		run_phase(int'($urandom_range(0, 2000)) - 1000, 16, 10, REC_MAX, 200, 5, 0, 1'b1);
		run_phase(int'($urandom_range(0, 2000)) - 1000, 8191, 5, REC_MAX, 200, 3, 0, 1'b0);
		// Lower the pre count while the memory still holds the larger fill.
		run_phase(int'($urandom_range(0, 2000)) - 1000, 4, 31, REC_MAX, 150, 5, 0, 1'b0);
		drain_flush();
		// Extension running into the record end.
		run_phase(32767, 6, 0, tracker.wr_pos + 60, 100, 5, 3, 1'b0);
		run_phase(int'($urandom_range(0, 2000)) - 1000, 0, 131071, 0, 100, 10, 0, 1'b0);
		drain_flush();

		// Let the last kept beats come out, then report.
		@(negedge clk);
		adc_valid <= 1'b0;
		for (waited = 0; waited < END_WAIT && tracker.pending_kept.size() != 0; waited++)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		tracker.close_out();
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> trigger_window_zero_suppression.f
hdl/twzs_pkg.sv
hdl/trigger_window_zero_suppression.sv
bench/trigger_window_zero_suppression_test.sv
